// ===== sv/imu_pf_pkg.sv =====
package imu_pf_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_FIRST = 8'h51;
    localparam logic [7:0] TYPE_LAST  = 8'h54;
    localparam int         PKT_LEN    = 11;
    localparam int         HIST_LEN   = PKT_LEN - 1;
    localparam int         PAY_LEN    = 8;

    typedef logic [7:0] t_byte;
    typedef logic [PAY_LEN-1:0][7:0] t_payload;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } t_det;

endpackage

// ===== sv/imu_packet_framer_top.sv =====
// Packet framer for an 11-byte sensor stream.
// Input channel (s_axis): one received serial byte per item in tdata[7:0].
// Output channel (m_axis): one item per accepted packet; tuser carries the
// packet kind (0 accel, 1 gyro, 2 angle, 3 magnetometer), tdata the eight
// payload bytes, payload byte 0 in the lowest byte.
// A packet is sync 0x55, a type 0x51..0x54, eight payload bytes and an
// 8-bit additive checksum over the first ten bytes. Failed windows slide
// forward one byte; a packet that overlaps the previous accepted packet is
// skipped.
// Throughput: one byte per cycle unless stalled. A ten-cell shift chain
// holds the window; a running sum makes each checksum test a single compare.
// Latency: the result appears in the cycle after the checksum byte is
// taken, held in one output register.
// Reset: window, sum and freshness marks clear; no packet can be reported
// until eleven new bytes have followed reset.
// Stall: while the output register holds an item that is not taken, input
// is refused; when the item is taken the next byte is accepted in the
// same cycle.
module imu_packet_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // payload_0 [7:0] .. payload_7 [63:56]
    output logic [1:0]  o_m_axis_tuser    // [1:0] packet_kind
);

    imu_pf_pkg::t_det     w_det;
    imu_pf_pkg::t_payload w_payload;
    logic                 w_s_acc;
    logic                 w_load;
    logic                 r_valid;
    logic                 n_valid;
    imu_pf_pkg::t_payload r_payload;
    logic [1:0]           r_kind;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = w_s_acc && w_det.hit;

    imu_pf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (w_s_acc),
        .i_byte    (i_s_axis_tdata),
        .o_det     (w_det),
        .o_payload (w_payload)
    );

    always_comb begin
        n_valid = r_valid;
        priority if (w_load) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_payload <= w_payload;
            r_kind    <= w_det.kind;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_payload;
    assign o_m_axis_tuser  = r_kind;

`ifndef SYNTH
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_hit_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_axis_tvalid && o_m_axis_tuser == $past(w_det.kind))
        else $error("accepted packet not presented");

    a_refuse_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_valid && !i_m_axis_tready)
        else $error("input refused without a stalled result");
`endif

endmodule

// ===== sv/imu_pf_cell.sv =====
module imu_pf_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_clear,
    input  imu_pf_pkg::t_byte i_byte,
    input  logic              i_fresh,
    output imu_pf_pkg::t_byte o_byte,
    output logic              o_fresh
);

    imu_pf_pkg::t_byte r_byte;
    logic              r_fresh;
    logic              n_fresh;

    // a byte that lands on an accepted packet no longer counts as fresh
    assign n_fresh = i_fresh & ~i_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte  <= '0;
            r_fresh <= 1'b0;
        end else if (i_shift) begin
            r_byte  <= i_byte;
            r_fresh <= n_fresh;
        end
    end

    assign o_byte  = r_byte;
    assign o_fresh = r_fresh;

endmodule

// ===== sv/imu_pf_window.sv =====
module imu_pf_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  imu_pf_pkg::t_byte    i_byte,
    output imu_pf_pkg::t_det     o_det,
    output imu_pf_pkg::t_payload o_payload
);

    localparam int N = imu_pf_pkg::HIST_LEN;

    imu_pf_pkg::t_byte w_byte  [N];
    logic [N-1:0]      w_fresh;
    imu_pf_pkg::t_byte r_sum;
    imu_pf_pkg::t_byte n_sum;
    imu_pf_pkg::t_byte w_kind_full;
    logic              w_hit;

    // cell 0 holds the oldest byte; new bytes enter at the top cell
    for (genvar g = 0; g < N; g++) begin : g_cell
        imu_pf_pkg::t_byte w_in;
        logic              w_fin;
        if (g == N - 1) begin : g_top
            assign w_in  = i_byte;
            assign w_fin = 1'b1;
        end else begin : g_mid
            assign w_in  = w_byte[g+1];
            assign w_fin = w_fresh[g+1];
        end
        imu_pf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_clear (w_hit),
            .i_byte  (w_in),
            .i_fresh (w_fin),
            .o_byte  (w_byte[g]),
            .o_fresh (w_fresh[g])
        );
    end

    // running mod-256 sum of the window: add the new byte, drop the oldest
    assign n_sum = r_sum - w_byte[0] + i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign w_hit = (&w_fresh)
                && (w_byte[0] == imu_pf_pkg::SYNC_BYTE)
                && (w_byte[1] >= imu_pf_pkg::TYPE_FIRST)
                && (w_byte[1] <= imu_pf_pkg::TYPE_LAST)
                && (r_sum == i_byte);

    assign w_kind_full = w_byte[1] - imu_pf_pkg::TYPE_FIRST;

    assign o_det.hit  = w_hit;
    assign o_det.kind = w_kind_full[1:0];

    for (genvar p = 0; p < imu_pf_pkg::PAY_LEN; p++) begin : g_pay
        assign o_payload[p] = w_byte[p+2];
    end

`ifndef SYNTH
    a_clear_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_shift && w_hit |=> w_fresh == '0)
        else $error("fresh marks not cleared after accepted packet");

    a_hit_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> w_fresh[0] && w_fresh[N-1])
        else $error("packet found in window with stale bytes");

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fresh[0] |-> w_fresh[N-1])
        else $error("fresh marks out of order");
`endif

endmodule
